@@ rtl/core/tmd_pkg.sv @@
// Shared types and constants of the switching median denoise block.
package tmd_pkg;

  localparam int PixW      = 8;
  localparam int ThrW      = 12;
  localparam int WidW      = 11;
  localparam int HgtW      = 12;
  localparam int RowW      = 12;
  localparam int CfgDataW  = 12;
  localparam int CfgIdxW   = 2;
  localparam int ProdW     = ThrW + PixW;
  localparam int WinSize   = 3;
  localparam int WinCells  = WinSize * WinSize;
  localparam int WinCenter = (WinCells - 1) / 2;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(26);
  localparam logic [WidW-1:0] WidReset = WidW'(640);
  localparam logic [HgtW-1:0] HgtReset = HgtW'(480);

  typedef logic [PixW-1:0] pixel_t;
  typedef pixel_t [WinCells-1:0] window_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    pixel_t pixel_in;
    logic   frame_start;
  } in_word_t;

  typedef struct packed {
    pixel_t pixel_out;
    logic   replaced;
    logic   last_of_frame;
  } out_word_t;

endpackage

@@ rtl/core/tmd_if.sv @@
// Valid/ready stream interfaces for the pixel input and the result output.
interface tmd_in_if;
  logic               valid;
  logic               ready;
  tmd_pkg::in_word_t  word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface tmd_out_if;
  logic               valid;
  logic               ready;
  tmd_pkg::out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

@@ rtl/core/threshold_median_denoise_3x3.sv @@
// Top level of the 3x3 switching median denoise filter.
// Takes one pixel per clock in raster order and never stalls on its own:
// the input is ready whenever the eight-word result queue has room for
// every result still in the pipeline. A pixel's result, if any, goes
// through the line-store read, the window shift, two median stages and
// the threshold test before it enters the result queue. Both line
// stores share one RAM of MAX_WIDTH words, read at accept and written
// in the following cycle, with a bypass when two consecutive pixels hit the
// same column. Border pixels give no result word.
module threshold_median_denoise_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tmd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tmd_pkg::CfgDataW-1:0]   cfg_data_i,
  tmd_in_if.sink                         pix_in_i,
  tmd_out_if.source                      pix_out_o
);

  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int WidthW = $clog2(MAX_WIDTH + 1);
  localparam int QDepth = 8;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);
  localparam int LineW  = 2 * tmd_pkg::PixW;

  // configuration
  logic [tmd_pkg::ThrW-1:0] thr_q;
  logic [tmd_pkg::WidW-1:0] wid_q;
  logic [tmd_pkg::HgtW-1:0] hgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= tmd_pkg::ThrReset;
      wid_q <= tmd_pkg::WidReset;
      hgt_q <= tmd_pkg::HgtReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmd_pkg::CFG_THRESHOLD:    thr_q <= cfg_data_i[tmd_pkg::ThrW-1:0];
        tmd_pkg::CFG_IMAGE_WIDTH:  wid_q <= cfg_data_i[tmd_pkg::WidW-1:0];
        tmd_pkg::CFG_IMAGE_HEIGHT: hgt_q <= cfg_data_i[tmd_pkg::HgtW-1:0];
        default: ;
      endcase
    end
  end

  logic [12:0]                 wid_ext, wid_clamp;
  logic [WidthW-1:0]           w_eff;
  logic [tmd_pkg::RowW-1:0]    h_eff;

  always_comb begin
    wid_ext = 13'(wid_q);
    if (wid_ext < 13'd3) begin
      wid_clamp = 13'd3;
    end else if (wid_ext > 13'(MAX_WIDTH)) begin
      wid_clamp = 13'(MAX_WIDTH);
    end else begin
      wid_clamp = wid_ext;
    end
    w_eff = WidthW'(wid_clamp);
    h_eff = (hgt_q < tmd_pkg::HgtW'(3)) ? tmd_pkg::RowW'(3) : tmd_pkg::RowW'(hgt_q);
  end

  // input handshake and raster counters
  logic                     accept, in_ready;
  logic [ColW-1:0]          col_q, col_d, col0, col1;
  logic [tmd_pkg::RowW-1:0] row_q, row_d, row0, row1, row2, row3;
  logic [WidthW-1:0]        col_inc;
  logic                     emit, last;

  assign accept         = pix_in_i.valid & in_ready;
  assign pix_in_i.ready = in_ready;

  always_comb begin
    col0 = pix_in_i.word.frame_start ? '0 : col_q;
    row0 = pix_in_i.word.frame_start ? '0 : row_q;
    if (WidthW'(col0) >= w_eff) begin
      col1 = '0;
      row1 = row0 + tmd_pkg::RowW'(1);
    end else begin
      col1 = col0;
      row1 = row0;
    end
    row2 = (row1 >= h_eff) ? '0 : row1;
    emit = (row2 >= tmd_pkg::RowW'(2)) && (col1 >= ColW'(2));
    last = (row2 == h_eff - tmd_pkg::RowW'(1)) &&
           (WidthW'(col1) == w_eff - WidthW'(1));
    col_inc = WidthW'(col1) + WidthW'(1);
    row3    = row2 + tmd_pkg::RowW'(1);
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row3 >= h_eff) ? '0 : row3;
    end else begin
      col_d = ColW'(col_inc);
      row_d = row2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores: upper in the high byte, lower in the low byte
  logic                    s1_valid_q, s1_emit_q, s1_last_q, s1_fwd_q;
  logic [ColW-1:0]         s1_addr_q;
  tmd_pkg::pixel_t         s1_pix_q, s1_fwd_up_q, s1_fwd_lo_q;
  logic [LineW-1:0]        line_rd;
  tmd_pkg::pixel_t         up_eff, lo_eff;

  assign lo_eff = s1_fwd_q ? s1_fwd_lo_q : line_rd[tmd_pkg::PixW-1:0];
  assign up_eff = s1_fwd_q ? s1_fwd_up_q : line_rd[LineW-1:tmd_pkg::PixW];

  tmd_ram #(
    .WIDTH (LineW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({lo_eff, s1_pix_q}),
    .re_i    (accept),
    .raddr_i (col1),
    .rdata_o (line_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  // bypass the write still in flight to the same column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q   <= emit;
      s1_last_q   <= last;
      s1_addr_q   <= col1;
      s1_pix_q    <= pix_in_i.word.pixel_in;
      s1_fwd_q    <= s1_valid_q && (s1_addr_q == col1);
      s1_fwd_up_q <= lo_eff;
      s1_fwd_lo_q <= s1_pix_q;
    end
  end

  // window shift
  tmd_pkg::window_t win_q, win_d;
  logic             s2_valid_q, s2_last_q;

  always_comb begin
    win_d = win_q;
    for (int r = 0; r < tmd_pkg::WinSize; r++) begin
      for (int c = 0; c < tmd_pkg::WinSize - 1; c++) begin
        win_d[r * tmd_pkg::WinSize + c] = win_q[r * tmd_pkg::WinSize + c + 1];
      end
    end
    win_d[tmd_pkg::WinSize - 1]      = up_eff;
    win_d[2 * tmd_pkg::WinSize - 1]  = lo_eff;
    win_d[tmd_pkg::WinCells - 1]     = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q & s1_emit_q;
      if (s1_valid_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_last_q <= s1_last_q;
  end

  // median
  tmd_pkg::pixel_t med;
  tmd_pkg::pixel_t s3_ctr_q, s4_ctr_q;
  logic            s3_valid_q, s3_last_q, s4_valid_q, s4_last_q;

  tmd_median9 u_median (
    .clk_i (clk_i),
    .win_i (win_q),
    .med_o (med)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_ctr_q  <= win_q[tmd_pkg::WinCenter];
    s3_last_q <= s2_last_q;
    s4_ctr_q  <= s3_ctr_q;
    s4_last_q <= s3_last_q;
  end

  // relative deviation test
  tmd_pkg::pixel_t            diff;
  logic [tmd_pkg::ProdW-1:0]  dev, lim;
  logic                       keep;
  tmd_pkg::out_word_t         res;

  always_comb begin
    diff = (med > s4_ctr_q) ? (med - s4_ctr_q) : (s4_ctr_q - med);
    dev  = tmd_pkg::ProdW'({diff, 8'h00});
    lim  = tmd_pkg::ProdW'(thr_q) * tmd_pkg::ProdW'(med);
    keep = dev <= lim;
    res.pixel_out     = keep ? s4_ctr_q : med;
    res.replaced      = ~keep;
    res.last_of_frame = s4_last_q;
  end

  // result queue
  tmd_pkg::out_word_t q_mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   q_cnt_q;
  logic [2:0]         pending;
  logic [QCntW:0]     reserved;
  logic               pop;

  assign pending  = 3'(s1_valid_q & s1_emit_q) + 3'(s2_valid_q) + 3'(s3_valid_q) +
                    3'(s4_valid_q);
  assign reserved = (QCntW + 1)'(q_cnt_q) + (QCntW + 1)'(pending);
  assign in_ready = reserved < (QCntW + 1)'(QDepth);
  assign pop      = pix_out_o.valid & pix_out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      if (s4_valid_q) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (s4_valid_q && !pop) begin
        q_cnt_q <= q_cnt_q + QCntW'(1);
      end else if (!s4_valid_q && pop) begin
        q_cnt_q <= q_cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_valid_q) begin
      q_mem_q[wr_ptr_q] <= res;
    end
  end

  assign pix_out_o.valid = q_cnt_q != '0;
  assign pix_out_o.word  = q_mem_q[rd_ptr_q];

endmodule

@@ rtl/core/tmd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module tmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tmd_median9.sv @@
// Two-stage registered median-of-nine sorting network.
module tmd_median9 (
  input  logic             clk_i,
  input  tmd_pkg::window_t win_i,
  output tmd_pkg::pixel_t  med_o
);

  function automatic tmd_pkg::window_t cmpx(tmd_pkg::window_t w, logic [3:0] a,
                                            logic [3:0] b);
    tmd_pkg::window_t r;
    r = w;
    if (w[a] > w[b]) begin
      r[a] = w[b];
      r[b] = w[a];
    end
    return r;
  endfunction

  tmd_pkg::window_t rows_d, rows_q, cols;
  tmd_pkg::pixel_t  med_q;

  // sort each row
  always_comb begin
    rows_d = win_i;
    rows_d = cmpx(rows_d, 4'd1, 4'd2);
    rows_d = cmpx(rows_d, 4'd4, 4'd5);
    rows_d = cmpx(rows_d, 4'd7, 4'd8);
    rows_d = cmpx(rows_d, 4'd0, 4'd1);
    rows_d = cmpx(rows_d, 4'd3, 4'd4);
    rows_d = cmpx(rows_d, 4'd6, 4'd7);
    rows_d = cmpx(rows_d, 4'd1, 4'd2);
    rows_d = cmpx(rows_d, 4'd4, 4'd5);
    rows_d = cmpx(rows_d, 4'd7, 4'd8);
  end

  // merge columns down to the middle element
  always_comb begin
    cols = rows_q;
    cols = cmpx(cols, 4'd0, 4'd3);
    cols = cmpx(cols, 4'd5, 4'd8);
    cols = cmpx(cols, 4'd4, 4'd7);
    cols = cmpx(cols, 4'd3, 4'd6);
    cols = cmpx(cols, 4'd1, 4'd4);
    cols = cmpx(cols, 4'd2, 4'd5);
    cols = cmpx(cols, 4'd4, 4'd7);
    cols = cmpx(cols, 4'd4, 4'd2);
    cols = cmpx(cols, 4'd6, 4'd4);
    cols = cmpx(cols, 4'd4, 4'd2);
  end

  always_ff @(posedge clk_i) begin
    rows_q <= rows_d;
    med_q  <= cols[tmd_pkg::WinCenter];
  end

  assign med_o = med_q;

endmodule
